// ===== rtl/one_wire_slave_link_and_rom_assert.svh =====
// Assertion macros for the one-wire slave checker.
// Depends on signals named clk and arst_n in the scope where a macro is used.
`ifndef ONE_WIRE_SLAVE_LINK_AND_ROM_ASSERT_SVH
`define ONE_WIRE_SLAVE_LINK_AND_ROM_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define OWSL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define OWSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/owsl_pkg.sv =====
// Shared types, reset values and codes for the one-wire slave link and ROM block.
// Used by every module of the block and by its checker; depends on nothing.
package owsl_pkg;

	// One bus edge event.
	typedef struct packed {
		logic        kind;
		logic [15:0] low_time;
	} in_t;

	// One result word per edge event.
	typedef struct packed {
		logic [9:0] drive_low;
		logic       bit_valid;
		logic       bit_value;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       reset_seen;
		logic       edge_unexpected;
	} out_t;

	// Configuration register set, handed from the register file to the core.
	typedef struct packed {
		logic [63:0] rom_id;
		logic [15:0] one_limit;
		logic [15:0] slot_max;
		logic [15:0] write_reset_min;
		logic [9:0]  zero_hold;
		logic [9:0]  presence_hold;
	} cfg_t;

	localparam int unsigned CfgIndexWidth = 3;

	// Configuration register indexes.
	localparam logic [CfgIndexWidth-1:0] RegRomId         = 3'd0;
	localparam logic [CfgIndexWidth-1:0] RegOneLimit      = 3'd1;
	localparam logic [CfgIndexWidth-1:0] RegSlotMax       = 3'd2;
	localparam logic [CfgIndexWidth-1:0] RegWriteResetMin = 3'd3;
	localparam logic [CfgIndexWidth-1:0] RegZeroHold      = 3'd4;
	localparam logic [CfgIndexWidth-1:0] RegPresenceHold  = 3'd5;

	// ROM command bytes.
	localparam logic [7:0] CmdSearchRom   = 8'hF0;
	localparam logic [7:0] CmdAlarmSearch = 8'hEC;
	localparam logic [7:0] CmdReadRom     = 8'h33;
	localparam logic [7:0] CmdMatchRom    = 8'h55;
	localparam logic [7:0] CmdSkipRom     = 8'hCC;

	localparam logic [63:0] RomIdReset         = 64'd0;
	localparam logic [15:0] OneLimitReset      = 16'd20;
	localparam logic [15:0] SlotMaxReset       = 16'd100;
	localparam logic [15:0] WriteResetMinReset = 16'd300;
	localparam logic [9:0]  ZeroHoldReset      = 10'd46;
	localparam logic [9:0]  PresenceHoldReset  = 10'd100;

endpackage

// ===== rtl/owsl_cfg.sv =====
// Configuration register file of the one-wire slave block.
// Depends on owsl_pkg for the register set type, register indexes and reset values.
module owsl_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [owsl_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [63:0]                          cfg_data,
	output owsl_pkg::cfg_t                       cfg
);

	owsl_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rom_id          <= owsl_pkg::RomIdReset;
			cfg_q.one_limit       <= owsl_pkg::OneLimitReset;
			cfg_q.slot_max        <= owsl_pkg::SlotMaxReset;
			cfg_q.write_reset_min <= owsl_pkg::WriteResetMinReset;
			cfg_q.zero_hold       <= owsl_pkg::ZeroHoldReset;
			cfg_q.presence_hold   <= owsl_pkg::PresenceHoldReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				owsl_pkg::RegRomId:         cfg_q.rom_id          <= cfg_data;
				owsl_pkg::RegOneLimit:      cfg_q.one_limit       <= cfg_data[15:0];
				owsl_pkg::RegSlotMax:       cfg_q.slot_max        <= cfg_data[15:0];
				owsl_pkg::RegWriteResetMin: cfg_q.write_reset_min <= cfg_data[15:0];
				owsl_pkg::RegZeroHold:      cfg_q.zero_hold       <= cfg_data[9:0];
				owsl_pkg::RegPresenceHold:  cfg_q.presence_hold   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/owsl_in_stage.sv =====
// Input register stage of the one-wire slave block.
// Depends on owsl_pkg for the edge event type.
module owsl_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ev_valid,
	output logic            ev_stall,
	input  owsl_pkg::in_t   ev_word,
	input  logic            take,
	output logic            valid_s1,
	output owsl_pkg::in_t   word_s1
);

	// The stage empties when the core takes its word, so it refills in the same cycle.
	assign ev_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!ev_stall) begin
			valid_s1 <= ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid && !ev_stall) begin
			word_s1 <= ev_word;
		end
	end

endmodule

// ===== rtl/owsl_core.sv =====
// Link layer and ROM command layer of the one-wire slave: state and one-pass step logic.
// Depends on owsl_pkg for the event, result and configuration types and the command codes.
module owsl_core (
	input  logic             clk,
	input  logic             arst_n,
	input  owsl_pkg::cfg_t   cfg,
	input  logic             go,
	input  owsl_pkg::in_t    item,
	output owsl_pkg::out_t   result
);

	localparam logic [2:0] LS_RX_IDLE  = 3'd0;
	localparam logic [2:0] LS_MASTER   = 3'd1;
	localparam logic [2:0] LS_PRESENCE = 3'd2;
	localparam logic [2:0] LS_TX_IDLE  = 3'd3;
	localparam logic [2:0] LS_TX_SLOT  = 3'd4;

	localparam logic [2:0] RP_WAIT    = 3'd0;
	localparam logic [2:0] RP_COMMAND = 3'd1;
	localparam logic [2:0] RP_PAYLOAD = 3'd2;
	localparam logic [2:0] RP_MATCH   = 3'd3;
	localparam logic [2:0] RP_SEARCH  = 3'd4;
	localparam logic [2:0] RP_ALARM   = 3'd5;

	logic [2:0]  link_q, link_n;
	logic [2:0]  phase_q, phase_n;
	logic [7:0]  rx_shift_q, rx_shift_n;
	logic [3:0]  rx_count_q, rx_count_n;
	logic [6:0]  idx_q, idx_n;
	logic [63:0] tx_bits_q, tx_bits_n;
	logic [6:0]  tx_left_q, tx_left_n;

	logic        bval;
	logic [7:0]  tk_shift;
	logic [3:0]  tk_count;
	logic        tk_done;
	logic [6:0]  idx_inc;
	logic        rom_bit_cur;
	logic        rom_bit_next;
	logic [6:0]  tx_left_dec;

	assign bval         = (item.low_time < cfg.one_limit);
	assign tk_shift     = rx_shift_q | (8'(bval) << rx_count_q[2:0]);
	assign tk_count     = rx_count_q + 4'd1;
	assign tk_done      = (tk_count >= 4'd8);
	assign idx_inc      = idx_q + 7'd1;
	assign rom_bit_cur  = cfg.rom_id[idx_q[5:0]];
	assign rom_bit_next = cfg.rom_id[idx_inc[5:0]];
	assign tx_left_dec  = (tx_left_q != 7'd0) ? (tx_left_q - 7'd1) : tx_left_q;

	always_comb begin
		link_n     = link_q;
		phase_n    = phase_q;
		rx_shift_n = rx_shift_q;
		rx_count_n = rx_count_q;
		idx_n      = idx_q;
		tx_bits_n  = tx_bits_q;
		tx_left_n  = tx_left_q;
		result     = '0;

		case (link_q)
			LS_RX_IDLE: begin
				if (item.kind) begin
					result.edge_unexpected = 1'b1;
				end else begin
					link_n = LS_MASTER;
				end
			end
			LS_MASTER: begin
				if (!item.kind) begin
					result.edge_unexpected = 1'b1;
				end else if (item.low_time <= cfg.slot_max) begin
					result.bit_valid = 1'b1;
					result.bit_value = bval;
					link_n = LS_RX_IDLE;
					case (phase_q)
						RP_COMMAND: begin
							if (!tk_done) begin
								rx_shift_n = tk_shift;
								rx_count_n = tk_count;
							end else begin
								rx_shift_n = 8'd0;
								rx_count_n = 4'd0;
								phase_n = RP_PAYLOAD;
								case (tk_shift)
									owsl_pkg::CmdSearchRom, owsl_pkg::CmdAlarmSearch: begin
										idx_n = 7'd0;
										phase_n = (tk_shift == owsl_pkg::CmdSearchRom) ?
											RP_SEARCH : RP_ALARM;
										tx_bits_n = {62'd0, ~cfg.rom_id[0], cfg.rom_id[0]};
										tx_left_n = 7'd2;
										link_n = LS_TX_IDLE;
									end
									owsl_pkg::CmdReadRom: begin
										tx_bits_n = cfg.rom_id;
										tx_left_n = 7'd64;
										link_n = LS_TX_IDLE;
									end
									owsl_pkg::CmdMatchRom: begin
										idx_n = 7'd0;
										phase_n = RP_MATCH;
									end
									owsl_pkg::CmdSkipRom: ;
									default: begin
										result.byte_valid = 1'b1;
										result.byte_value = tk_shift;
									end
								endcase
							end
						end
						RP_PAYLOAD: begin
							if (!tk_done) begin
								rx_shift_n = tk_shift;
								rx_count_n = tk_count;
							end else begin
								rx_shift_n = 8'd0;
								rx_count_n = 4'd0;
								result.byte_valid = 1'b1;
								result.byte_value = tk_shift;
							end
						end
						RP_MATCH, RP_SEARCH, RP_ALARM: begin
							if (bval != rom_bit_cur) begin
								phase_n = RP_WAIT;
							end else begin
								idx_n = idx_inc;
								if (idx_inc[6]) begin
									phase_n = RP_PAYLOAD;
									rx_shift_n = 8'd0;
									rx_count_n = 4'd0;
								end else if (phase_q != RP_MATCH) begin
									// Next search pair: the ROM bit, then its complement.
									tx_bits_n = {62'd0, ~rom_bit_next, rom_bit_next};
									tx_left_n = 7'd2;
									link_n = LS_TX_IDLE;
								end
							end
						end
						default: begin
							phase_n = RP_WAIT;
						end
					endcase
				end else begin
					result.drive_low  = cfg.presence_hold;
					result.reset_seen = 1'b1;
					phase_n    = RP_COMMAND;
					rx_shift_n = 8'd0;
					rx_count_n = 4'd0;
					tx_bits_n  = 64'd0;
					tx_left_n  = 7'd0;
					link_n     = LS_PRESENCE;
				end
			end
			LS_PRESENCE: begin
				// Our own presence pulse pulls the bus low; only the release matters.
				if (item.kind) begin
					link_n = LS_RX_IDLE;
				end
			end
			LS_TX_IDLE: begin
				if (item.kind) begin
					result.edge_unexpected = 1'b1;
				end else begin
					if (!tx_bits_q[0]) begin
						result.drive_low = cfg.zero_hold;
					end
					link_n = LS_TX_SLOT;
				end
			end
			LS_TX_SLOT: begin
				if (!item.kind) begin
					result.edge_unexpected = 1'b1;
				end else if (item.low_time > cfg.write_reset_min) begin
					result.drive_low  = cfg.presence_hold;
					result.reset_seen = 1'b1;
					phase_n    = RP_COMMAND;
					rx_shift_n = 8'd0;
					rx_count_n = 4'd0;
					tx_bits_n  = 64'd0;
					tx_left_n  = 7'd0;
					link_n     = LS_PRESENCE;
				end else begin
					tx_bits_n = tx_bits_q >> 1;
					tx_left_n = tx_left_dec;
					link_n = (tx_left_dec != 7'd0) ? LS_TX_IDLE : LS_RX_IDLE;
				end
			end
			default: begin
				link_n = LS_RX_IDLE;
				result.edge_unexpected = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q     <= LS_RX_IDLE;
			phase_q    <= RP_WAIT;
			rx_shift_q <= 8'd0;
			rx_count_q <= 4'd0;
			idx_q      <= 7'd0;
			tx_bits_q  <= 64'd0;
			tx_left_q  <= 7'd0;
		end else if (go) begin
			link_q     <= link_n;
			phase_q    <= phase_n;
			rx_shift_q <= rx_shift_n;
			rx_count_q <= rx_count_n;
			idx_q      <= idx_n;
			tx_bits_q  <= tx_bits_n;
			tx_left_q  <= tx_left_n;
		end
	end

endmodule

// ===== rtl/owsl_out_stage.sv =====
// Result register stage of the one-wire slave block.
// Depends on owsl_pkg for the result word type.
module owsl_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  owsl_pkg::out_t   result,
	output logic             adv,
	output logic             res_valid,
	input  logic             res_stall,
	output owsl_pkg::out_t   res_word
);

	logic go;

	// The register can load when it is empty or its word leaves this cycle.
	assign adv = !res_valid || !res_stall;
	assign go  = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_word <= result;
		end
	end

endmodule

// ===== rtl/one_wire_slave_link_and_rom.sv =====
// One-wire slave link layer and ROM command layer, one bus edge event per word.
// Each edge word is registered in the input stage, then its result word in the result stage.
// Throughput: one edge word per cycle; a stalled result word holds the core and the input.
// Reset: arst_n clears link and ROM state and restores configuration defaults at once.
module one_wire_slave_link_and_rom (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 ev_valid,
	output logic                                 ev_stall,
	input  owsl_pkg::in_t                        ev_word,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output owsl_pkg::out_t                       res_word,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [owsl_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [63:0]                          cfg_data
);

	// Datapath: an input register holds the edge word, the core works out the
	// next link and ROM state together with the result word in one combinational
	// pass, and the result register keeps the word until the consumer takes it.
	// The core only advances when the result register can load, so the state
	// never runs ahead of the delivered words.

	owsl_pkg::cfg_t cfg;
	owsl_pkg::in_t  word_s1;
	owsl_pkg::out_t result;
	logic           valid_s1;
	logic           adv;
	logic           go;

	assign go = valid_s1 && adv;

	// Register writes are taken at any time; the block expects them only when idle.
	owsl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owsl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (ev_valid),
		.ev_stall (ev_stall),
		.ev_word  (ev_word),
		.take     (adv),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	// Link states and ROM phases live here; search and read ROM load the
	// transmit shifter, match and search walk the ROM bit index.
	owsl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.go     (go),
		.item   (word_s1),
		.result (result)
	);

	owsl_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.adv       (adv),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

// ===== rtl/owsl_checker.sv =====
// Port-level checker for the one-wire slave block, bound to the top level.
// Depends on owsl_pkg and the assertion macros in one_wire_slave_link_and_rom_assert.svh.
`include "one_wire_slave_link_and_rom_assert.svh"

module owsl_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  logic             res_stall,
	input  owsl_pkg::out_t   res_word
);

	// A held result word stays put until it is taken.
	`OWSL_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word), "result word changed while stalled")

	// A completed byte always comes with the bit that completed it.
	`OWSL_ASSERT_NOW(a_byte_has_bit, res_valid && res_word.byte_valid, res_word.bit_valid, "byte reported without a received bit")

	// Fields without their valid flag read as zero.
	`OWSL_ASSERT_NOW(a_quiet_fields, res_valid && !res_word.byte_valid, (res_word.byte_value == 8'd0) && (!res_word.bit_value || res_word.bit_valid), "value field set without its valid flag")

	// A bus reset word carries no bit, byte or unexpected-edge event.
	`OWSL_ASSERT_NOW(a_reset_alone, res_valid && res_word.reset_seen, !res_word.bit_valid && !res_word.byte_valid && !res_word.edge_unexpected, "bus reset word carries other events")

endmodule

bind one_wire_slave_link_and_rom owsl_checker u_owsl_checker (.*);

// ===== test/one_wire_slave_link_and_rom_test.sv =====
// Self-checking testbench for the one-wire slave link and ROM command block.
// Depends on owsl_pkg and the one_wire_slave_link_and_rom RTL; drives bus edge words
// through the handshakes and checks every result word against an in-bench predictor.
module one_wire_slave_link_and_rom_test;

	// Link layer states, ROM layer phases and low time kinds, as the predictor tracks them.
	typedef enum logic [2:0] {
		LINK_RX_IDLE, LINK_MASTER, LINK_PRESENCE, LINK_TX_IDLE, LINK_TX_SLOT
	} link_e;

	typedef enum logic [2:0] {
		PH_WAIT, PH_COMMAND, PH_PAYLOAD, PH_MATCH, PH_SEARCH, PH_ALARM
	} rom_phase_e;

	// Kinds of low time the stimulus asks for; the value is picked from the live config.
	typedef enum logic [2:0] {
		LOW_ONE, LOW_ZERO, LOW_BUS_RESET, LOW_READ, LOW_READ_RESET
	} low_e;

	localparam int unsigned NumRegs = 6;

	// The predictor lives in this class. Every accepted edge word advances its copy of the
	// link and ROM state and queues the result word the block must produce for it; every
	// accepted result word is checked against the oldest queued one.
	class edge_result_board;
		owsl_pkg::cfg_t cfg;
		link_e link;
		rom_phase_e phase;
		logic [7:0] rx_shift;
		logic [3:0] rx_count;
		logic [6:0] bit_index;
		logic [63:0] tx_bits;
		logic [6:0] tx_left;
		owsl_pkg::out_t expected_q[$];
		int unsigned errors;

		function new();
			cfg = '{owsl_pkg::RomIdReset, owsl_pkg::OneLimitReset, owsl_pkg::SlotMaxReset,
				owsl_pkg::WriteResetMinReset, owsl_pkg::ZeroHoldReset,
				owsl_pkg::PresenceHoldReset};
			link = LINK_RX_IDLE;
			phase = PH_WAIT;
			rx_shift = '0;
			rx_count = '0;
			bit_index = '0;
			tx_bits = '0;
			tx_left = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [owsl_pkg::CfgIndexWidth-1:0] idx, logic [63:0] value);
			case (idx)
				owsl_pkg::RegRomId: cfg.rom_id = value;
				owsl_pkg::RegOneLimit: cfg.one_limit = value[15:0];
				owsl_pkg::RegSlotMax: cfg.slot_max = value[15:0];
				owsl_pkg::RegWriteResetMin: cfg.write_reset_min = value[15:0];
				owsl_pkg::RegZeroHold: cfg.zero_hold = value[9:0];
				owsl_pkg::RegPresenceHold: cfg.presence_hold = value[9:0];
				default: ;
			endcase
		endfunction

		function logic rom_bit(logic [6:0] idx);
			return cfg.rom_id[idx[5:0]];
		endfunction

		// A search step sends the ROM bit and then its complement before the master answers.
		function void load_search_pair();
			logic b;
			b = rom_bit(bit_index);
			tx_bits = {62'd0, ~b, b};
			tx_left = 7'd2;
			link = LINK_TX_IDLE;
		endfunction

		// Shifts one master bit in, LSB first; returns 1 with the byte once eight are in.
		function logic take_bit(logic b, output logic [7:0] full);
			rx_shift = rx_shift | (8'(b) << rx_count[2:0]);
			rx_count++;
			if (rx_count < 4'd8)
				return 1'b0;
			full = rx_shift;
			rx_shift = '0;
			rx_count = '0;
			return 1'b1;
		endfunction

		function void bus_reset();
			phase = PH_COMMAND;
			rx_shift = '0;
			rx_count = '0;
			tx_bits = '0;
			tx_left = '0;
			link = LINK_PRESENCE;
		endfunction

		function void note_edge(owsl_pkg::in_t ev);
			owsl_pkg::out_t o;
			logic [7:0] full;
			logic b;
			o = '0;
			case (link)
				LINK_RX_IDLE: begin
					if (ev.kind)
						o.edge_unexpected = 1'b1;
					else
						link = LINK_MASTER;
				end
				LINK_MASTER: begin
					if (!ev.kind) begin
						o.edge_unexpected = 1'b1;
					end else if (ev.low_time <= cfg.slot_max) begin
						b = ev.low_time < cfg.one_limit;
						o.bit_valid = 1'b1;
						o.bit_value = b;
						link = LINK_RX_IDLE;
						case (phase)
							PH_COMMAND: begin
								if (take_bit(b, full)) begin
									phase = PH_PAYLOAD;
									case (full)
										owsl_pkg::CmdSearchRom, owsl_pkg::CmdAlarmSearch: begin
											bit_index = '0;
											phase = (full == owsl_pkg::CmdSearchRom) ?
												PH_SEARCH : PH_ALARM;
											load_search_pair();
										end
										owsl_pkg::CmdReadRom: begin
											tx_bits = cfg.rom_id;
											tx_left = 7'd64;
											link = LINK_TX_IDLE;
										end
										owsl_pkg::CmdMatchRom: begin
											bit_index = '0;
											phase = PH_MATCH;
										end
										owsl_pkg::CmdSkipRom: ;
										default: begin
											o.byte_valid = 1'b1;
											o.byte_value = full;
										end
									endcase
								end
							end
							PH_PAYLOAD: begin
								if (take_bit(b, full)) begin
									o.byte_valid = 1'b1;
									o.byte_value = full;
								end
							end
							PH_MATCH, PH_SEARCH, PH_ALARM: begin
								// A wrong bit silences the ROM layer until the next bus reset.
								if (b != rom_bit(bit_index)) begin
									phase = PH_WAIT;
								end else begin
									bit_index++;
									if (bit_index >= 7'd64) begin
										phase = PH_PAYLOAD;
										rx_shift = '0;
										rx_count = '0;
									end else if (phase != PH_MATCH) begin
										load_search_pair();
									end
								end
							end
							default: phase = PH_WAIT;
						endcase
					end else begin
						o.drive_low = cfg.presence_hold;
						o.reset_seen = 1'b1;
						bus_reset();
					end
				end
				LINK_PRESENCE: begin
					// Our own presence pulse pulls the bus low; only its release matters.
					if (ev.kind)
						link = LINK_RX_IDLE;
				end
				LINK_TX_IDLE: begin
					if (ev.kind) begin
						o.edge_unexpected = 1'b1;
					end else begin
						if (!tx_bits[0])
							o.drive_low = cfg.zero_hold;
						link = LINK_TX_SLOT;
					end
				end
				LINK_TX_SLOT: begin
					if (!ev.kind) begin
						o.edge_unexpected = 1'b1;
					end else if (ev.low_time > cfg.write_reset_min) begin
						o.drive_low = cfg.presence_hold;
						o.reset_seen = 1'b1;
						bus_reset();
					end else begin
						tx_bits = tx_bits >> 1;
						if (tx_left > 0)
							tx_left--;
						link = (tx_left > 0) ? LINK_TX_IDLE : LINK_RX_IDLE;
					end
				end
				default: begin
					link = LINK_RX_IDLE;
					o.edge_unexpected = 1'b1;
				end
			endcase
			expected_q.push_back(o);
		endfunction

		function void check_result(owsl_pkg::out_t got);
			owsl_pkg::out_t want;
			if (expected_q.size() == 0) begin
				$error("result word arrived with no expectation pending");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.drive_low !== want.drive_low) begin
				$error("drive_low: expected %0d, got %0d", want.drive_low, got.drive_low);
				errors++;
			end
			if (got.bit_valid !== want.bit_valid) begin
				$error("bit_valid: expected %0d, got %0d", want.bit_valid, got.bit_valid);
				errors++;
			end
			if (got.bit_value !== want.bit_value) begin
				$error("bit_value: expected %0d, got %0d", want.bit_value, got.bit_value);
				errors++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
				errors++;
			end
			if (got.byte_value !== want.byte_value) begin
				$error("byte_value: expected 0x%02h, got 0x%02h", want.byte_value,
					got.byte_value);
				errors++;
			end
			if (got.reset_seen !== want.reset_seen) begin
				$error("reset_seen: expected %0d, got %0d", want.reset_seen, got.reset_seen);
				errors++;
			end
			if (got.edge_unexpected !== want.edge_unexpected) begin
				$error("edge_unexpected: expected %0d, got %0d", want.edge_unexpected,
					got.edge_unexpected);
				errors++;
			end
		endfunction
	endclass

	// Every block input has a known value from time zero on.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic ev_valid = 1'b0;
	logic ev_stall;
	owsl_pkg::in_t ev_word = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	owsl_pkg::out_t res_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [owsl_pkg::CfgIndexWidth-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	edge_result_board sb;

	// Percent chances, per cycle, that the sender idles and that the receiver stalls.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// The command the stimulus spells out after each bus reset rotates through every ROM
	// command and then an arbitrary byte, which the block reports as an unknown command.
	logic [7:0] cmd_plan = owsl_pkg::CmdSkipRom;
	int unsigned cmd_turn = 0;
	logic [7:0] command_list [5] = '{owsl_pkg::CmdSearchRom, owsl_pkg::CmdAlarmSearch,
		owsl_pkg::CmdReadRom, owsl_pkg::CmdMatchRom, owsl_pkg::CmdSkipRom};

	one_wire_slave_link_and_rom dut (
		.clk(clk),
		.arst_n(arst_n),
		.ev_valid(ev_valid),
		.ev_stall(ev_stall),
		.ev_word(ev_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Result side: a word is taken at an edge where valid is high and our stall is low.
	// Both are read before this edge's updates land, so the check never races the block.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res_word);
		res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic roll(int unsigned per_mille);
		return $urandom_range(999) < per_mille;
	endfunction

	// Picks a low time of the requested kind under the configuration now in force. Where the
	// configuration leaves no such value, any value is taken and the predictor sorts it out.
	function automatic logic [15:0] pick_low(low_e k);
		int unsigned lo, hi, ol, sm, wr;
		ol = sb.cfg.one_limit;
		sm = sb.cfg.slot_max;
		wr = sb.cfg.write_reset_min;
		lo = 0;
		hi = 65535;
		case (k)
			LOW_ONE: hi = (ol == 0) ? sm : ((ol - 1 < sm) ? ol - 1 : sm);
			LOW_ZERO: begin
				lo = (ol <= sm) ? ol : 0;
				hi = sm;
			end
			LOW_BUS_RESET: lo = (sm < 65535) ? sm + 1 : 65535;
			LOW_READ: hi = wr;
			LOW_READ_RESET: lo = (wr < 65535) ? wr + 1 : 65535;
			default: ;
		endcase
		return 16'($urandom_range(hi, lo));
	endfunction

	// A plausible bus: a short data slot, a longer slot window, a reset threshold at or above it.
	function automatic owsl_pkg::cfg_t typical_cfg();
		owsl_pkg::cfg_t c;
		c.rom_id = {$urandom, $urandom};
		c.one_limit = 16'($urandom_range(60, 1));
		c.slot_max = c.one_limit + 16'($urandom_range(200, 5));
		c.write_reset_min = c.slot_max + 16'($urandom_range(400, 0));
		c.zero_hold = 10'($urandom);
		c.presence_hold = 10'($urandom);
		return c;
	endfunction

	// Sends one edge word. Valid stays high from one word to the next unless the sender
	// decides to idle first, so it is never lowered and raised at the same edge.
	task automatic send_edge(logic kind, logic [15:0] low_time);
		while (roll(send_idle_pct * 10)) begin
			ev_valid <= 1'b0;
			@(posedge clk);
		end
		ev_valid <= 1'b1;
		ev_word <= '{kind: kind, low_time: low_time};
		do @(posedge clk); while (ev_stall);
		sb.note_edge(ev_word);
	endtask

	// Stops sending and waits until every expected result word has been taken. Since each
	// edge word makes exactly one result word, the block is idle once the queue is empty.
	task automatic drain();
		ev_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Writes all registers back to back; valid stays up across the whole burst.
	task automatic configure(owsl_pkg::cfg_t c);
		logic [63:0] vals [NumRegs];
		logic [owsl_pkg::CfgIndexWidth-1:0] regs [NumRegs];
		vals = '{c.rom_id, 64'(c.one_limit), 64'(c.slot_max), 64'(c.write_reset_min),
			64'(c.zero_hold), 64'(c.presence_hold)};
		regs = '{owsl_pkg::RegRomId, owsl_pkg::RegOneLimit, owsl_pkg::RegSlotMax,
			owsl_pkg::RegWriteResetMin, owsl_pkg::RegZeroHold, owsl_pkg::RegPresenceHold};
		cfg_valid <= 1'b1;
		for (int i = 0; i < NumRegs; i++) begin
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Chooses the next edge from the predicted link state so that most traffic is a
	// well-formed bus: slots close with the right polarity, commands are spelled out bit by
	// bit, ROM compares mostly match, and read slots follow the slave's own sends. A small
	// share is wrong-polarity noise, failed compares and resets in the middle of things.
	task automatic random_edge();
		logic want;
		case (sb.link)
			LINK_RX_IDLE: begin
				if (roll(30)) begin
					send_edge(1'b1, 16'($urandom));
				end else begin
					if (sb.phase == PH_COMMAND && sb.rx_count == 0) begin
						cmd_plan = (cmd_turn % 6 == 5) ? 8'($urandom) :
							command_list[cmd_turn % 6];
						cmd_turn++;
					end
					send_edge(1'b0, 16'($urandom));
				end
			end
			LINK_MASTER: begin
				// A silenced slave gets reset soon; payload gets a few bytes before the next one.
				if (roll(30)) begin
					send_edge(1'b0, 16'($urandom));
				end else if (roll(sb.phase == PH_WAIT ? 250 :
						(sb.phase == PH_PAYLOAD ? 30 : 5))) begin
					send_edge(1'b1, pick_low(LOW_BUS_RESET));
				end else begin
					case (sb.phase)
						PH_COMMAND: want = cmd_plan[sb.rx_count[2:0]];
						PH_MATCH, PH_SEARCH, PH_ALARM:
							want = sb.cfg.rom_id[sb.bit_index[5:0]] ^ roll(10);
						default: want = 1'($urandom_range(1));
					endcase
					send_edge(1'b1, pick_low(want ? LOW_ONE : LOW_ZERO));
				end
			end
			LINK_PRESENCE: send_edge(roll(800), 16'($urandom));
			LINK_TX_IDLE: send_edge(roll(30), 16'($urandom));
			default: begin
				if (roll(30))
					send_edge(1'b0, 16'($urandom));
				else
					send_edge(1'b1, pick_low(roll(20) ? LOW_READ_RESET : LOW_READ));
			end
		endcase
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset configuration, no idling. A rising edge with no slot open
		// and a falling edge inside an open slot are both flagged and ignored.
		send_edge(1'b1, 16'hFFFF);
		send_edge(1'b0, 16'h0000);
		send_edge(1'b0, 16'hFFFF);
		// Master bits before any bus reset are reported but never decoded as a command.
		// The low times sit right at the bit-one limit and at the slot maximum.
		send_edge(1'b1, 16'd0);
		send_edge(1'b0, 16'h5A5A);
		send_edge(1'b1, owsl_pkg::OneLimitReset - 16'd1);
		send_edge(1'b0, 16'hA5A5);
		send_edge(1'b1, owsl_pkg::OneLimitReset);
		send_edge(1'b0, 16'h0000);
		send_edge(1'b1, owsl_pkg::SlotMaxReset);
		// Just past the slot maximum is a bus reset, answered by a presence pulse. The
		// falling edges of our own pulse are swallowed and its release ends it.
		send_edge(1'b0, 16'hFFFF);
		send_edge(1'b1, owsl_pkg::SlotMaxReset + 16'd1);
		send_edge(1'b0, 16'h0000);
		send_edge(1'b0, 16'hFFFF);
		send_edge(1'b1, 16'hFFFF);
		// The longest possible low time is a bus reset as well.
		send_edge(1'b0, 16'h0000);
		send_edge(1'b1, 16'hFFFF);
		send_edge(1'b0, 16'h0000);
		send_edge(1'b1, 16'd0);
		repeat (100) random_edge();

		// Random device identity and timing, sender idling.
		drain();
		configure(typical_cfg());
		send_idle_pct = 59;
		repeat (160) random_edge();

		// Every register at its lowest value, receiver stalling.
		drain();
		configure('0);
		send_idle_pct = 0;
		recv_stall_pct = 59;
		repeat (50) random_edge();

		// Every register at its highest value, both sides idling.
		drain();
		configure('1);
		send_idle_pct = 38;
		recv_stall_pct = 38;
		repeat (50) random_edge();

		// Receiver stalling; halfway through the sender waits until the block has emptied.
		drain();
		configure(typical_cfg());
		send_idle_pct = 0;
		recv_stall_pct = 59;
		repeat (85) random_edge();
		drain();
		repeat (85) random_edge();

		// Both sides idling to the end.
		drain();
		configure(typical_cfg());
		send_idle_pct = 38;
		recv_stall_pct = 38;
		repeat (200) random_edge();

		// Waiting on after the drain catches any stray extra result word.
		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
